[hw/rtl/sc1a_pkg.sv]
// Shared types and constants of the set 1 scan code decoder.
// Scan code values, result codes and the two translation tables.
// No dependencies.
package sc1a_pkg;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_ACK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_NAV  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      NAV_LEFT   = 3'd0,
      NAV_RIGHT  = 3'd1,
      NAV_UP     = 3'd2,
      NAV_DOWN   = 3'd3,
      NAV_HOME   = 3'd4,
      NAV_END    = 3'd5,
      NAV_DELETE = 3'd6
   } nav_type;

   localparam int unsigned BREAK_BIT = 7;

   localparam logic [7:0] SC_F12         = 8'h58;
   localparam logic [7:0] SC_PREFIX      = 8'hE0;
   localparam logic [7:0] SC_SHIFT_L     = 8'h2A;
   localparam logic [7:0] SC_SHIFT_R     = 8'h36;
   localparam logic [7:0] SC_SHIFT_L_BRK = 8'hAA;
   localparam logic [7:0] SC_SHIFT_R_BRK = 8'hB6;
   localparam logic [7:0] SC_CAPS        = 8'h3A;
   localparam logic [7:0] SC_TABLE_LEN   = 8'd59;
   localparam logic [7:0] SC_LETTER_LO   = 8'h10;
   localparam logic [7:0] SC_LETTER_HI   = 8'h32;

   localparam logic [7:0] SC_NAV_LEFT    = 8'h4B;
   localparam logic [7:0] SC_NAV_RIGHT   = 8'h4D;
   localparam logic [7:0] SC_NAV_UP      = 8'h48;
   localparam logic [7:0] SC_NAV_DOWN    = 8'h50;
   localparam logic [7:0] SC_NAV_HOME    = 8'h47;
   localparam logic [7:0] SC_NAV_END     = 8'h4F;
   localparam logic [7:0] SC_NAV_DELETE  = 8'h53;

   localparam logic [6:0] ASCII_LOWER_A  = 7'h61;
   localparam logic [6:0] ASCII_LOWER_Z  = 7'h7A;

   // Padded to 64 entries; codes from 59 upwards read as zero.
   localparam logic [6:0] PLAIN_TAB [0:63] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [6:0] SHIFTED_TAB [0:63] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

endpackage

[hw/rtl/sc1a_req_if.sv]
// Input channel of the scan code decoder: valid, ready and one scan item.
// Depends on sc1a_pkg for the operation code type.
interface sc1a_req_if;
   logic             valid;
   logic             ready;
   sc1a_pkg::op_type op;
   logic [7:0]       scan_byte;

   modport source (output valid, op, scan_byte, input ready);
   modport sink   (input valid, op, scan_byte, output ready);
endinterface

[hw/rtl/sc1a_rsp_if.sv]
// Result channel of the scan code decoder: valid, ready and one result item.
// Depends on sc1a_pkg for the kind and navigation key types.
interface sc1a_rsp_if;
   logic               valid;
   logic               ready;
   sc1a_pkg::kind_type kind;
   logic [6:0]         character;
   sc1a_pkg::nav_type  nav_key;
   logic               to_raw;
   logic               stop_requested;

   modport source (output valid, kind, character, nav_key, to_raw, stop_requested,
                   input ready);
   modport sink   (input valid, kind, character, nav_key, to_raw, stop_requested,
                   output ready);
endinterface

[hw/rtl/sc1a_csr_if.sv]
// Configuration write channel of the scan code decoder: raw mode bit.
// No dependencies.
interface sc1a_csr_if;
   logic valid;
   logic ready;
   logic raw_en;

   modport source (output valid, raw_en, input ready);
   modport sink   (input valid, raw_en, output ready);
endinterface

[hw/rtl/scancode_set1_to_ascii_decoder.sv]
// Set 1 scan code to ASCII decoder, top level.
// Input register, then result register; decode and state update is one table lookup deep.
// Throughput: 1 item per cycle unless a waiting result is not taken (rsp.ready low).
// Reset: synchronous, active high; clears shift, caps lock, prefix, stop flag, raw mode
// and both valid bits. Configuration writes are taken in every cycle.
// Depends on sc1a_pkg and the sc1a_req_if, sc1a_rsp_if and sc1a_csr_if interfaces.
module scancode_set1_to_ascii_decoder (
   input  logic        clock,
   input  logic        reset,
   sc1a_req_if.sink    req,
   sc1a_rsp_if.source  rsp,
   sc1a_csr_if.sink    csr
);

   // Input register
   logic             in_valid_ff;
   sc1a_pkg::op_type in_op_ff;
   logic [7:0]       in_byte_ff;

   // Keyboard state
   logic raw_en_ff;
   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic prefix_ff, prefix_in;
   logic stop_ff, stop_in;

   // Result register
   logic               rsp_valid_ff;
   sc1a_pkg::kind_type kind_ff, kind_in;
   logic [6:0]         char_ff, char_in;
   sc1a_pkg::nav_type  nav_ff, nav_in;
   logic               to_raw_ff, to_raw_in;

   // Decode helpers
   logic                advance;
   logic                is_break;
   logic [5:0]          tab_idx;
   logic [6:0]          plain_char;
   logic [6:0]          shifted_char;
   logic                shift_sel;
   logic [6:0]          sel_char;
   logic                nav_hit;
   sc1a_pkg::nav_type   nav_code;

   // The input register moves on whenever the result register is free or being
   // emptied, so a new transfer is taken while a finished result still waits.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.character      = char_ff;
   assign rsp.nav_key        = nav_ff;
   assign rsp.to_raw         = to_raw_ff;
   assign rsp.stop_requested = stop_ff;

   assign is_break     = in_byte_ff[sc1a_pkg::BREAK_BIT];
   assign tab_idx      = in_byte_ff[5:0];
   assign plain_char   = sc1a_pkg::PLAIN_TAB[tab_idx];
   assign shifted_char = sc1a_pkg::SHIFTED_TAB[tab_idx];

   // Caps lock flips shift only on the letter rows, and only where the plain
   // entry really is a lowercase letter.
   always_comb begin
      shift_sel = shift_ff;
      if (caps_ff && in_byte_ff >= sc1a_pkg::SC_LETTER_LO
          && in_byte_ff <= sc1a_pkg::SC_LETTER_HI
          && plain_char >= sc1a_pkg::ASCII_LOWER_A
          && plain_char <= sc1a_pkg::ASCII_LOWER_Z) begin
         shift_sel = !shift_ff;
      end
   end

   assign sel_char = shift_sel ? shifted_char : plain_char;

   // Navigation key lookup for the byte that follows the extended prefix.
   always_comb begin
      nav_hit  = 1'b1;
      nav_code = sc1a_pkg::NAV_LEFT;
      case (in_byte_ff)
         sc1a_pkg::SC_NAV_LEFT:   nav_code = sc1a_pkg::NAV_LEFT;
         sc1a_pkg::SC_NAV_RIGHT:  nav_code = sc1a_pkg::NAV_RIGHT;
         sc1a_pkg::SC_NAV_UP:     nav_code = sc1a_pkg::NAV_UP;
         sc1a_pkg::SC_NAV_DOWN:   nav_code = sc1a_pkg::NAV_DOWN;
         sc1a_pkg::SC_NAV_HOME:   nav_code = sc1a_pkg::NAV_HOME;
         sc1a_pkg::SC_NAV_END:    nav_code = sc1a_pkg::NAV_END;
         sc1a_pkg::SC_NAV_DELETE: nav_code = sc1a_pkg::NAV_DELETE;
         default:                 nav_hit  = 1'b0;
      endcase
   end

   // Decision order: acknowledge, F12, prefix, byte after prefix, shift make,
   // shift break, caps lock, other breaks, table lookup.
   always_comb begin
      shift_in  = shift_ff;
      caps_in   = caps_ff;
      prefix_in = prefix_ff;
      stop_in   = stop_ff;
      kind_in   = sc1a_pkg::KIND_NONE;
      char_in   = '0;
      nav_in    = sc1a_pkg::NAV_LEFT;
      to_raw_in = 1'b0;

      if (in_op_ff == sc1a_pkg::OP_ACK) begin
         stop_in = 1'b0;
      end else if (in_byte_ff == sc1a_pkg::SC_F12) begin
         // Hold a pending prefix across F12.
         stop_in = 1'b1;
      end else if (in_byte_ff == sc1a_pkg::SC_PREFIX) begin
         prefix_in = 1'b1;
      end else if (prefix_ff) begin
         prefix_in = 1'b0;
         if (!is_break && !raw_en_ff && nav_hit) begin
            kind_in = sc1a_pkg::KIND_NAV;
            nav_in  = nav_code;
         end
      end else if (in_byte_ff inside {sc1a_pkg::SC_SHIFT_L, sc1a_pkg::SC_SHIFT_R}) begin
         shift_in = 1'b1;
      end else if (in_byte_ff inside {sc1a_pkg::SC_SHIFT_L_BRK, sc1a_pkg::SC_SHIFT_R_BRK}) begin
         shift_in = 1'b0;
      end else if (in_byte_ff == sc1a_pkg::SC_CAPS) begin
         caps_in = !caps_ff;
      end else if (!is_break && in_byte_ff < sc1a_pkg::SC_TABLE_LEN) begin
         // Empty table entries produce nothing.
         if (sel_char != '0) begin
            kind_in   = sc1a_pkg::KIND_CHAR;
            char_in   = sel_char;
            to_raw_in = raw_en_ff;
         end
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         raw_en_ff    <= 1'b0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         prefix_ff    <= 1'b0;
         stop_ff      <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (csr.valid) begin
            raw_en_ff <= csr.raw_en;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            shift_ff     <= shift_in;
            caps_ff      <= caps_in;
            prefix_ff    <= prefix_in;
            stop_ff      <= stop_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff   <= req.op;
         in_byte_ff <= req.scan_byte;
      end
      if (advance) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         nav_ff    <= nav_in;
         to_raw_ff <= to_raw_in;
      end
   end

endmodule
